// ===== hw/rtl/aluc_pkg.sv =====
// types, operation codes and branch conditions of the execute unit
package aluc_pkg;

  typedef enum logic [5:0] {
    OP_CLR  = 6'd0,
    OP_CLRB = 6'd1,
    OP_COM  = 6'd2,
    OP_COMB = 6'd3,
    OP_INC  = 6'd4,
    OP_INCB = 6'd5,
    OP_DEC  = 6'd6,
    OP_DECB = 6'd7,
    OP_NEG  = 6'd8,
    OP_NEGB = 6'd9,
    OP_TST  = 6'd10,
    OP_TSTB = 6'd11,
    OP_MOV  = 6'd12,
    OP_MOVB = 6'd13,
    OP_CMP  = 6'd14,
    OP_CMPB = 6'd15,
    OP_ADD  = 6'd16,
    OP_SUB  = 6'd17,
    OP_BR   = 6'd18,
    OP_BNE  = 6'd19,
    OP_BEQ  = 6'd20,
    OP_BGE  = 6'd21,
    OP_BLT  = 6'd22,
    OP_BGT  = 6'd23,
    OP_BLE  = 6'd24,
    OP_BPL  = 6'd25,
    OP_BMI  = 6'd26,
    OP_BHI  = 6'd27,
    OP_BLOS = 6'd28,
    OP_BVC  = 6'd29,
    OP_BVS  = 6'd30,
    OP_BCC  = 6'd31,
    OP_BCS  = 6'd32
  } op_e;

  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [5:0]       op;
    logic [WordW-1:0] src_value;
    logic [WordW-1:0] dst_value;
    logic             dest_is_register;
    logic [ByteW-1:0] branch_offset;
    logic [WordW-1:0] pc_in;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] result_word;
    logic             write_result;
    logic [WordW-1:0] pc_out;
    logic             branch_taken;
    flags_t           flags_out;
  } result_t;

  function automatic logic branch_cond(logic [5:0] op, flags_t f);
    logic t;
    t = 1'b0;
    case (op)
      OP_BR:   t = 1'b1;
      OP_BNE:  t = !f.z;
      OP_BEQ:  t = f.z;
      OP_BGE:  t = (f.n == f.v);
      OP_BLT:  t = (f.n != f.v);
      OP_BGT:  t = !(f.z || (f.n != f.v));
      OP_BLE:  t = f.z || (f.n != f.v);
      OP_BPL:  t = !f.n;
      OP_BMI:  t = f.n;
      OP_BHI:  t = !(f.c || f.z);
      OP_BLOS: t = f.c || f.z;
      OP_BVC:  t = !f.v;
      OP_BVS:  t = f.v;
      OP_BCC:  t = !f.c;
      OP_BCS:  t = f.c;
      default: t = 1'b0;
    endcase
    return t;
  endfunction

endpackage

// ===== hw/rtl/aluc_if.sv =====
// valid/ready channels for instruction items and result items
interface aluc_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  op;
  logic [15:0] src_value;
  logic [15:0] dst_value;
  logic        dest_is_register;
  logic [7:0]  branch_offset;
  logic [15:0] pc_in;

  modport source (output valid, op, src_value, dst_value, dest_is_register,
                  branch_offset, pc_in, input ready);
  modport sink (input valid, op, src_value, dst_value, dest_is_register,
                branch_offset, pc_in, output ready);
endinterface

interface aluc_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_word;
  logic        write_result;
  logic [15:0] pc_out;
  logic        branch_taken;
  logic [3:0]  flags_out;

  modport source (output valid, result_word, write_result, pc_out, branch_taken,
                  flags_out, input ready);
  modport sink (input valid, result_word, write_result, pc_out, branch_taken,
                flags_out, output ready);
endinterface

// ===== hw/rtl/aluc_exec.sv =====
// combinational operation decode, arithmetic, flag and branch logic
module aluc_exec (
  input  aluc_pkg::item_t   item_i,
  input  aluc_pkg::flags_t  flags_i,
  output aluc_pkg::result_t res_o
);

  logic [15:0] dst;
  logic [15:0] src;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [7:0]  sb;
  logic [15:0] inc_w;
  logic [15:0] dec_w;
  logic [15:0] neg_w;
  logic [7:0]  inc_b;
  logic [7:0]  dec_b;
  logic [7:0]  neg_b;
  logic [16:0] add_w;
  logic [16:0] sub_w;
  logic [16:0] cmp_w;
  logic [8:0]  cmp_b;
  logic [15:0] off_x2;

  assign dst    = item_i.dst_value;
  assign src    = item_i.src_value;
  assign lo     = dst[7:0];
  assign hi     = dst[15:8];
  assign sb     = src[7:0];
  assign inc_w  = dst + 16'd1;
  assign dec_w  = dst - 16'd1;
  assign neg_w  = 16'd0 - dst;
  assign inc_b  = lo + 8'd1;
  assign dec_b  = lo - 8'd1;
  assign neg_b  = 8'd0 - lo;
  assign add_w  = {1'b0, src} + {1'b0, dst};
  assign sub_w  = {1'b0, dst} - {1'b0, src};
  assign cmp_w  = {1'b0, src} - {1'b0, dst};
  assign cmp_b  = {1'b0, sb} - {1'b0, lo};
  assign off_x2 = {{7{item_i.branch_offset[7]}}, item_i.branch_offset, 1'b0};

  always_comb begin
    aluc_pkg::result_t r;
    aluc_pkg::flags_t  f;
    r = '0;
    f = flags_i;
    r.pc_out = item_i.pc_in;
    unique case (item_i.op)
      aluc_pkg::OP_CLR: begin
        r.write_result = 1'b1;
        f = '{n: 1'b0, z: 1'b1, v: 1'b0, c: 1'b0};
      end
      aluc_pkg::OP_CLRB: begin
        r.result_word  = {hi, 8'h00};
        r.write_result = 1'b1;
        f = '{n: 1'b0, z: 1'b1, v: 1'b0, c: 1'b0};
      end
      aluc_pkg::OP_COM: begin
        r.result_word  = ~dst;
        r.write_result = 1'b1;
        f = '{n: ~dst[15], z: (dst == 16'hffff), v: 1'b0, c: 1'b1};
      end
      aluc_pkg::OP_COMB: begin
        r.result_word  = {hi, ~lo};
        r.write_result = 1'b1;
        f = '{n: ~lo[7], z: (lo == 8'hff), v: 1'b0, c: 1'b1};
      end
      aluc_pkg::OP_INC: begin
        r.result_word  = inc_w;
        r.write_result = 1'b1;
        f = '{n: inc_w[15], z: (inc_w == 16'd0), v: (dst == 16'h7fff), c: flags_i.c};
      end
      aluc_pkg::OP_INCB: begin
        r.result_word  = {hi, inc_b};
        r.write_result = 1'b1;
        f = '{n: inc_b[7], z: (inc_b == 8'd0), v: (lo == 8'h7f), c: flags_i.c};
      end
      aluc_pkg::OP_DEC: begin
        r.result_word  = dec_w;
        r.write_result = 1'b1;
        f = '{n: dec_w[15], z: (dec_w == 16'd0), v: (dst == 16'h8000), c: flags_i.c};
      end
      aluc_pkg::OP_DECB: begin
        r.result_word  = {hi, dec_b};
        r.write_result = 1'b1;
        f = '{n: dec_b[7], z: (dec_b == 8'd0), v: (lo == 8'h80), c: flags_i.c};
      end
      aluc_pkg::OP_NEG: begin
        r.result_word  = neg_w;
        r.write_result = 1'b1;
        f = '{n: neg_w[15], z: (neg_w == 16'd0), v: (neg_w == 16'h8000),
              c: (neg_w != 16'd0)};
      end
      aluc_pkg::OP_NEGB: begin
        r.result_word  = {hi, neg_b};
        r.write_result = 1'b1;
        f = '{n: neg_b[7], z: (neg_b == 8'd0), v: (neg_b == 8'h80),
              c: (neg_b != 8'd0)};
      end
      aluc_pkg::OP_TST: begin
        f = '{n: dst[15], z: (dst == 16'd0), v: 1'b0, c: 1'b0};
      end
      aluc_pkg::OP_TSTB: begin
        f = '{n: lo[7], z: (lo == 8'd0), v: 1'b0, c: 1'b0};
      end
      aluc_pkg::OP_MOV: begin
        r.result_word  = src;
        r.write_result = 1'b1;
        f = '{n: src[15], z: (src == 16'd0), v: 1'b0, c: flags_i.c};
      end
      aluc_pkg::OP_MOVB: begin
        r.result_word  = item_i.dest_is_register ? {{8{sb[7]}}, sb} : {hi, sb};
        r.write_result = 1'b1;
        f = '{n: sb[7], z: (sb == 8'd0), v: 1'b0, c: flags_i.c};
      end
      aluc_pkg::OP_CMP: begin
        f = '{n: cmp_w[15], z: (cmp_w[15:0] == 16'd0),
              v: (src[15] ^ dst[15]) & ~(dst[15] ^ cmp_w[15]), c: cmp_w[16]};
      end
      aluc_pkg::OP_CMPB: begin
        f = '{n: cmp_b[7], z: (cmp_b[7:0] == 8'd0),
              v: (sb[7] ^ lo[7]) & ~(lo[7] ^ cmp_b[7]), c: cmp_b[8]};
      end
      aluc_pkg::OP_ADD: begin
        r.result_word  = add_w[15:0];
        r.write_result = 1'b1;
        f = '{n: add_w[15], z: (add_w[15:0] == 16'd0),
              v: ~(src[15] ^ dst[15]) & (dst[15] ^ add_w[15]), c: add_w[16]};
      end
      aluc_pkg::OP_SUB: begin
        r.result_word  = sub_w[15:0];
        r.write_result = 1'b1;
        f = '{n: sub_w[15], z: (sub_w[15:0] == 16'd0),
              v: (src[15] ^ dst[15]) & ~(src[15] ^ sub_w[15]), c: sub_w[16]};
      end
      default: begin
        if (aluc_pkg::branch_cond(item_i.op, flags_i)) begin
          r.branch_taken = 1'b1;
          r.pc_out       = item_i.pc_in + off_x2;
        end
      end
    endcase
    r.flags_out = f;
    res_o = r;
  end

endmodule

// ===== hw/rtl/alu_condition_codes_and_branch.sv =====
// execute unit top: input register, execute logic, flag register, result register
// an accepted item passes the input register, then the result register
// throughput: 1 item per cycle unless the result side stalls; the flag register feeds
// the execute logic directly, so each item sees the flags left by the one before it
// reset: clears the flags to zero and empties both pipeline registers
module alu_condition_codes_and_branch (
  input  logic        clk_i,
  input  logic        rst_ni,
  aluc_in_if.sink     in_i,
  aluc_res_if.source  res_o
);

  logic                s1_valid_q;
  aluc_pkg::item_t     s1_q;
  aluc_pkg::item_t     s1_d;
  logic                out_valid_q;
  aluc_pkg::result_t   out_q;
  aluc_pkg::result_t   exec_res;
  aluc_pkg::flags_t    flags_q;
  logic                advance;
  logic                move;
  logic                in_fire;

  assign advance = !out_valid_q || res_o.ready;
  assign move    = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire = in_i.valid && in_i.ready;

  assign s1_d = '{op: in_i.op, src_value: in_i.src_value, dst_value: in_i.dst_value,
                  dest_is_register: in_i.dest_is_register,
                  branch_offset: in_i.branch_offset, pc_in: in_i.pc_in};

  aluc_exec u_exec (
    .item_i  (s1_q),
    .flags_i (flags_q),
    .res_o   (exec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (move) begin
        flags_q <= exec_res.flags_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (move) begin
      out_q <= exec_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_word  = out_q.result_word;
  assign res_o.write_result = out_q.write_result;
  assign res_o.pc_out       = out_q.pc_out;
  assign res_o.branch_taken = out_q.branch_taken;
  assign res_o.flags_out    = out_q.flags_out;

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> flags_q == $past(flags_q))
    else $error("flags changed without an item moving to the result register");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.flags_out == flags_q)
    else $error("shown flags differ from the flag register");

  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted item lost from the input register");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_q))
    else $error("stalled item dropped from the input register");

  a_branch_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.branch_taken |-> !out_q.write_result)
    else $error("taken branch also writes a result");

endmodule

// ===== test/tb.sv =====
// testbench of the execute unit: directed and random items checked against a flag-tracking predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 488;
  localparam logic [15:0] CornerWords [12] = '{
    16'h0000, 16'h0001, 16'h007f, 16'h0080, 16'h00ff, 16'h7fff,
    16'h8000, 16'hffff, 16'hff00, 16'h7f80, 16'h807f, 16'hff7f
  };

  logic clk = 1'b0;
  logic rst_n;

  aluc_in_if  in_if ();
  aluc_res_if res_if ();

  alu_condition_codes_and_branch i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  aluc_pkg::flags_t  cc_shadow;
  aluc_pkg::result_t expected_results [$];
  int unsigned       src_idle_pct;
  int unsigned       snk_idle_pct;
  int unsigned       errors = 0;
  int unsigned       cycles = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  function automatic aluc_pkg::flags_t nz_word(input logic [15:0] x);
    aluc_pkg::flags_t f;
    f = '0;
    f.n = x[15];
    f.z = (x == 16'h0000);
    return f;
  endfunction

  function automatic aluc_pkg::flags_t nz_byte(input logic [7:0] x);
    aluc_pkg::flags_t f;
    f = '0;
    f.n = x[7];
    f.z = (x == 8'h00);
    return f;
  endfunction

  function automatic logic branch_holds(input logic [5:0] op, input aluc_pkg::flags_t f);
    logic lt;
    lt = f.n ^ f.v;
    case (op)
      aluc_pkg::OP_BR:   return 1'b1;
      aluc_pkg::OP_BNE:  return !f.z;
      aluc_pkg::OP_BEQ:  return f.z;
      aluc_pkg::OP_BGE:  return !lt;
      aluc_pkg::OP_BLT:  return lt;
      aluc_pkg::OP_BGT:  return !(f.z || lt);
      aluc_pkg::OP_BLE:  return f.z || lt;
      aluc_pkg::OP_BPL:  return !f.n;
      aluc_pkg::OP_BMI:  return f.n;
      aluc_pkg::OP_BHI:  return !(f.c || f.z);
      aluc_pkg::OP_BLOS: return f.c || f.z;
      aluc_pkg::OP_BVC:  return !f.v;
      aluc_pkg::OP_BVS:  return f.v;
      aluc_pkg::OP_BCC:  return !f.c;
      aluc_pkg::OP_BCS:  return f.c;
      default:           return 1'b0;
    endcase
  endfunction

  // executes one instruction item and advances the shadow condition codes
  function automatic aluc_pkg::result_t execute_insn(input aluc_pkg::item_t it);
    aluc_pkg::result_t r;
    aluc_pkg::flags_t  f;
    logic [15:0] s;
    logic [15:0] d;
    logic [15:0] w;
    logic [7:0]  lo;
    logic [7:0]  sb;
    logic [7:0]  b;
    logic [16:0] sum;
    f = cc_shadow;
    r = '0;
    r.pc_out = it.pc_in;
    s = it.src_value;
    d = it.dst_value;
    lo = d[7:0];
    sb = s[7:0];
    case (it.op)
      aluc_pkg::OP_CLR: begin
        r.write_result = 1'b1;
        f = nz_word(16'h0000);
      end
      aluc_pkg::OP_CLRB: begin
        r.result_word = {d[15:8], 8'h00};
        r.write_result = 1'b1;
        f = nz_byte(8'h00);
      end
      aluc_pkg::OP_COM: begin
        w = ~d;
        r.result_word = w;
        r.write_result = 1'b1;
        f = nz_word(w);
        f.c = 1'b1;
      end
      aluc_pkg::OP_COMB: begin
        b = ~lo;
        r.result_word = {d[15:8], b};
        r.write_result = 1'b1;
        f = nz_byte(b);
        f.c = 1'b1;
      end
      aluc_pkg::OP_INC: begin
        w = d + 16'd1;
        r.result_word = w;
        r.write_result = 1'b1;
        f = nz_word(w);
        f.v = (d == 16'h7fff);
        f.c = cc_shadow.c;
      end
      aluc_pkg::OP_INCB: begin
        b = lo + 8'd1;
        r.result_word = {d[15:8], b};
        r.write_result = 1'b1;
        f = nz_byte(b);
        f.v = (lo == 8'h7f);
        f.c = cc_shadow.c;
      end
      aluc_pkg::OP_DEC: begin
        w = d - 16'd1;
        r.result_word = w;
        r.write_result = 1'b1;
        f = nz_word(w);
        f.v = (d == 16'h8000);
        f.c = cc_shadow.c;
      end
      aluc_pkg::OP_DECB: begin
        b = lo - 8'd1;
        r.result_word = {d[15:8], b};
        r.write_result = 1'b1;
        f = nz_byte(b);
        f.v = (lo == 8'h80);
        f.c = cc_shadow.c;
      end
      aluc_pkg::OP_NEG: begin
        w = 16'h0000 - d;
        r.result_word = w;
        r.write_result = 1'b1;
        f = nz_word(w);
        f.v = (w == 16'h8000);
        f.c = (w != 16'h0000);
      end
      aluc_pkg::OP_NEGB: begin
        b = 8'h00 - lo;
        r.result_word = {d[15:8], b};
        r.write_result = 1'b1;
        f = nz_byte(b);
        f.v = (b == 8'h80);
        f.c = (b != 8'h00);
      end
      aluc_pkg::OP_TST:  f = nz_word(d);
      aluc_pkg::OP_TSTB: f = nz_byte(lo);
      aluc_pkg::OP_MOV: begin
        r.result_word = s;
        r.write_result = 1'b1;
        f = nz_word(s);
        f.c = cc_shadow.c;
      end
      aluc_pkg::OP_MOVB: begin
        r.result_word = it.dest_is_register ? {{8{sb[7]}}, sb} : {d[15:8], sb};
        r.write_result = 1'b1;
        f = nz_byte(sb);
        f.c = cc_shadow.c;
      end
      aluc_pkg::OP_CMP: begin
        w = s - d;
        f = nz_word(w);
        f.v = (s[15] != d[15]) && (d[15] == w[15]);
        f.c = (s < d);
      end
      aluc_pkg::OP_CMPB: begin
        b = sb - lo;
        f = nz_byte(b);
        f.v = (sb[7] != lo[7]) && (lo[7] == b[7]);
        f.c = (sb < lo);
      end
      aluc_pkg::OP_ADD: begin
        sum = {1'b0, s} + {1'b0, d};
        w = sum[15:0];
        r.result_word = w;
        r.write_result = 1'b1;
        f = nz_word(w);
        f.v = (s[15] == d[15]) && (d[15] != w[15]);
        f.c = sum[16];
      end
      aluc_pkg::OP_SUB: begin
        w = d - s;
        r.result_word = w;
        r.write_result = 1'b1;
        f = nz_word(w);
        f.v = (s[15] != d[15]) && (s[15] == w[15]);
        f.c = (d < s);
      end
      default: begin
        if (it.op >= aluc_pkg::OP_BR && it.op <= aluc_pkg::OP_BCS &&
            branch_holds(it.op, f)) begin
          r.branch_taken = 1'b1;
          r.pc_out = it.pc_in + {{7{it.branch_offset[7]}}, it.branch_offset, 1'b0};
        end
      end
    endcase
    cc_shadow = f;
    r.flags_out = f;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    aluc_pkg::result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result item with nothing pending: expected none actual %h %b %h %b %h",
                 $time, res_if.result_word, res_if.write_result, res_if.pc_out,
                 res_if.branch_taken, res_if.flags_out);
      end else begin
        want = expected_results.pop_front();
        check_field("result_word", want.result_word, res_if.result_word);
        check_field("write_result", 16'(want.write_result), 16'(res_if.write_result));
        check_field("pc_out", want.pc_out, res_if.pc_out);
        check_field("branch_taken", 16'(want.branch_taken), 16'(res_if.branch_taken));
        check_field("flags_out", 16'(want.flags_out), 16'(res_if.flags_out));
      end
    end
  end

  task automatic send_item(input aluc_pkg::item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.op               <= it.op;
    in_if.src_value        <= it.src_value;
    in_if.dst_value        <= it.dst_value;
    in_if.dest_is_register <= it.dest_is_register;
    in_if.branch_offset    <= it.branch_offset;
    in_if.pc_in            <= it.pc_in;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(execute_insn(it));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic aluc_pkg::item_t make_item(input logic [5:0] op,
                                                input logic [15:0] src,
                                                input logic [15:0] dst, input logic dreg,
                                                input logic [7:0] off,
                                                input logic [15:0] pc);
    aluc_pkg::item_t it;
    it.op = op;
    it.src_value = src;
    it.dst_value = dst;
    it.dest_is_register = dreg;
    it.branch_offset = off;
    it.pc_in = pc;
    return it;
  endfunction

  function automatic logic [15:0] pick_word();
    if ($urandom_range(3) == 0) return CornerWords[$urandom_range(11)];
    return 16'($urandom);
  endfunction

  function automatic aluc_pkg::item_t random_item();
    logic [5:0] op;
    if ($urandom_range(99) < 5) op = 6'($urandom_range(63, 33));
    else op = 6'($urandom_range(32, 0));
    return make_item(op, pick_word(), pick_word(), 1'($urandom_range(1)),
                     8'($urandom_range(255)), 16'($urandom));
  endfunction

  task automatic test_single_operand();
    send_item(make_item(aluc_pkg::OP_CLR,  16'h1234, 16'hffff, 1'b0, 8'h00, 16'h1000));
    send_item(make_item(aluc_pkg::OP_CLRB, 16'h0000, 16'hffff, 1'b1, 8'h00, 16'h1002));
    send_item(make_item(aluc_pkg::OP_COM,  16'hffff, 16'h0000, 1'b0, 8'hff, 16'h1004));
    send_item(make_item(aluc_pkg::OP_COMB, 16'h0000, 16'h12ff, 1'b0, 8'h00, 16'h1006));
    send_item(make_item(aluc_pkg::OP_INC,  16'h0000, 16'h7fff, 1'b0, 8'h00, 16'h1008));
    send_item(make_item(aluc_pkg::OP_INCB, 16'h0000, 16'hab7f, 1'b0, 8'h00, 16'h100a));
    send_item(make_item(aluc_pkg::OP_DEC,  16'h0000, 16'h8000, 1'b0, 8'h00, 16'h100c));
    send_item(make_item(aluc_pkg::OP_DECB, 16'h0000, 16'h5580, 1'b0, 8'h00, 16'h100e));
    send_item(make_item(aluc_pkg::OP_NEG,  16'h0000, 16'h0000, 1'b0, 8'h00, 16'h1010));
    send_item(make_item(aluc_pkg::OP_NEGB, 16'h0000, 16'hff80, 1'b0, 8'h00, 16'h1012));
    send_item(make_item(aluc_pkg::OP_TST,  16'h0000, 16'h8000, 1'b0, 8'h00, 16'h1014));
    send_item(make_item(aluc_pkg::OP_TSTB, 16'h0000, 16'hff00, 1'b0, 8'h00, 16'h1016));
  endtask

  task automatic test_double_operand();
    send_item(make_item(aluc_pkg::OP_MOV,  16'h0000, 16'hffff, 1'b0, 8'h00, 16'h2000));
    send_item(make_item(aluc_pkg::OP_MOVB, 16'h0080, 16'h1234, 1'b1, 8'h00, 16'h2002));
    send_item(make_item(aluc_pkg::OP_MOVB, 16'hff80, 16'h1234, 1'b0, 8'h00, 16'h2004));
    send_item(make_item(aluc_pkg::OP_CMP,  16'h8000, 16'h0001, 1'b0, 8'h00, 16'h2006));
    send_item(make_item(aluc_pkg::OP_CMPB, 16'h007f, 16'h0080, 1'b0, 8'h00, 16'h2008));
    send_item(make_item(aluc_pkg::OP_ADD,  16'hffff, 16'h0001, 1'b0, 8'h00, 16'h200a));
    send_item(make_item(aluc_pkg::OP_SUB,  16'h0001, 16'h8000, 1'b0, 8'h00, 16'h200c));
  endtask

  task automatic test_branches();
    send_item(make_item(aluc_pkg::OP_BR,   16'h0000, 16'h0000, 1'b0, 8'h80, 16'h0000));
    send_item(make_item(aluc_pkg::OP_BNE,  16'h0000, 16'h0000, 1'b0, 8'h7f, 16'hfff0));
    send_item(make_item(aluc_pkg::OP_BEQ,  16'h0000, 16'h0000, 1'b0, 8'hff, 16'h3000));
    send_item(make_item(aluc_pkg::OP_BLT,  16'h0000, 16'h0000, 1'b0, 8'h01, 16'h3002));
    send_item(make_item(aluc_pkg::OP_BHI,  16'h0000, 16'h0000, 1'b0, 8'hfe, 16'h3004));
    send_item(make_item(aluc_pkg::OP_BCS,  16'h0000, 16'h0000, 1'b0, 8'h10, 16'h3006));
  endtask

  task automatic test_unused_codes();
    send_item(make_item(6'd33, 16'hffff, 16'hffff, 1'b1, 8'hff, 16'hffff));
    send_item(make_item(6'd63, 16'hffff, 16'hffff, 1'b1, 8'hff, 16'hffff));
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (PhaseItems) send_item(random_item());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0);
    run_phase(45, 0);
    run_phase(0, 45);
    run_phase(14, 14);
  endtask

  initial begin
    cc_shadow = '0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    rst_n                  <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.op               <= '0;
    in_if.src_value        <= '0;
    in_if.dst_value        <= '0;
    in_if.dest_is_register <= 1'b0;
    in_if.branch_offset    <= '0;
    in_if.pc_in            <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_operand();
    test_double_operand();
    test_branches();
    test_unused_codes();
    wait_drained();
    test_random_traffic();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
